FILE: rtl/core/lbsc_pkg.sv
// Shared types, codes and constants of the light blind stepper controller.
// Used by every module in rtl/core; depends on nothing else.
package lbsc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 5;

    localparam logic [7:0] CHAR_LIGHT  = 8'h6C;
    localparam logic [7:0] CHAR_MANUAL = 8'h6D;
    localparam logic [7:0] CHAR_OPEN   = 8'h6F;
    localparam logic [7:0] CHAR_CLOSE  = 8'h63;

    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_LIGHT_MODE   = 3'd1;
    localparam logic [2:0] EV_MANUAL_MODE  = 3'd2;
    localparam logic [2:0] EV_OPENED       = 3'd3;
    localparam logic [2:0] EV_CLOSED       = 3'd4;
    localparam logic [2:0] EV_INVALID      = 3'd5;
    localparam logic [2:0] EV_OPENED_LIGHT = 3'd6;
    localparam logic [2:0] EV_CLOSED_LIGHT = 3'd7;

    localparam logic [2:0] REG_OPEN_THR    = 3'd0;
    localparam logic [2:0] REG_CLOSE_THR   = 3'd1;
    localparam logic [2:0] REG_OPEN_STEPS  = 3'd2;
    localparam logic [2:0] REG_CLOSE_STEPS = 3'd3;
    localparam logic [2:0] REG_COOLDOWN    = 3'd4;
    localparam logic [2:0] REG_STEP_TICKS  = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_LIGHT,
        OP_MANUAL,
        OP_OPEN,
        OP_CLOSE,
        OP_INVALID
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [9:0] sample;
    } item_t;

    typedef struct packed {
        logic [9:0]  open_thr;
        logic [9:0]  close_thr;
        logic [15:0] open_count;
        logic [15:0] close_count;
        logic [15:0] cooldown_len;
        logic [7:0]  step_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic       blind_is_open;
        logic       light_mode_on;
        logic       motor_busy;
        logic [2:0] event_code;
    } result_t;

    function automatic logic [3:0] coil_of(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

FILE: rtl/core/lbsc_front.sv
// Front end: accepts input items and decodes each into a queue operation.
// Depends on lbsc_pkg.
module lbsc_front (
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [9:0]            light_sample,
    input  logic [7:0]            command_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output lbsc_pkg::item_t       q_item
);
    import lbsc_pkg::*;

    op_t cmd_op;

    always_comb
    begin
        unique case (command_byte)
            CHAR_LIGHT:  cmd_op = OP_LIGHT;
            CHAR_MANUAL: cmd_op = OP_MANUAL;
            CHAR_OPEN:   cmd_op = OP_OPEN;
            CHAR_CLOSE:  cmd_op = OP_CLOSE;
            default:     cmd_op = OP_INVALID;
        endcase
    end

    assign q_item.op     = mode ? cmd_op : OP_TICK;
    assign q_item.sample = light_sample;
    assign in_stall      = q_full;
    assign q_push        = in_valid && !q_full;

endmodule

FILE: rtl/core/lbsc_queue.sv
// Short queue of decoded operations between the front end and the back end.
// Depends on lbsc_pkg.
module lbsc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lbsc_pkg::item_t       push_item,
    input  logic                  pop,
    output lbsc_pkg::item_t       head_item,
    output logic                  empty,
    output logic                  full
);
    import lbsc_pkg::*;

    item_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/lbsc_back.sv
// Back end: carries out decoded operations on the blind and motor state and
// holds each result in an output register. Depends on lbsc_pkg.
module lbsc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbsc_pkg::cfg_t        cfg,
    input  logic                  q_empty,
    input  lbsc_pkg::item_t       q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lbsc_pkg::result_t     result
);
    import lbsc_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic        open_reg, open_next;
    logic        light_reg, light_next;
    logic        moving_reg, moving_next;
    logic        dir_reg, dir_next;
    logic        by_light_reg, by_light_next;
    logic [15:0] steps_reg, steps_next;
    logic [7:0]  tdiv_reg, tdiv_next;
    logic [15:0] cool_reg, cool_next;
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic        start, start_dir, start_light, finish;
    logic [2:0]  ev;
    logic [7:0]  tdiv_inc, period;
    logic [15:0] steps_dec, start_count;

    assign q_pop     = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        open_next     = open_reg;
        light_next    = light_reg;
        moving_next   = moving_reg;
        dir_next      = dir_reg;
        by_light_next = by_light_reg;
        steps_next    = steps_reg;
        tdiv_next     = tdiv_reg;
        cool_next     = cool_reg;
        start         = 1'b0;
        start_dir     = 1'b0;
        start_light   = 1'b0;
        finish        = 1'b0;
        ev            = EV_NONE;
        tdiv_inc      = tdiv_reg + 8'd1;
        period        = (cfg.step_ticks == 8'd0) ? 8'd1 : cfg.step_ticks;
        steps_dec     = steps_reg - 16'd1;

        case (q_item.op)
            OP_LIGHT:
            begin
                light_next = 1'b1;
                ev         = EV_LIGHT_MODE;
            end
            OP_MANUAL:
            begin
                light_next = 1'b0;
                ev         = EV_MANUAL_MODE;
            end
            OP_OPEN:
            begin
                if (!moving_reg && !light_reg && !open_reg)
                begin
                    start     = 1'b1;
                    start_dir = 1'b1;
                end
            end
            OP_CLOSE:
            begin
                if (!moving_reg && !light_reg && open_reg)
                begin
                    start = 1'b1;
                end
            end
            OP_INVALID:
            begin
                ev = EV_INVALID;
            end
            default:
            begin
                if (moving_reg)
                begin
                    if (tdiv_inc >= period)
                    begin
                        tdiv_next  = 8'd0;
                        phase_next = dir_reg ? phase_reg + 3'd1 : phase_reg - 3'd1;
                        steps_next = steps_dec;
                        finish     = (steps_dec == 16'd0);
                    end
                    else
                    begin
                        tdiv_next = tdiv_inc;
                    end
                end
                else if (cool_reg != 16'd0)
                begin
                    cool_next = cool_reg - 16'd1;
                end
                else if (light_reg)
                begin
                    if (!open_reg && q_item.sample > cfg.open_thr)
                    begin
                        start       = 1'b1;
                        start_dir   = 1'b1;
                        start_light = 1'b1;
                    end
                    else if (open_reg && q_item.sample < cfg.close_thr)
                    begin
                        start       = 1'b1;
                        start_light = 1'b1;
                    end
                end
            end
        endcase

        start_count = start_dir ? cfg.open_count : cfg.close_count;
        if (start)
        begin
            dir_next      = start_dir;
            by_light_next = start_light;
            steps_next    = start_count;
            tdiv_next     = 8'd0;
            moving_next   = 1'b1;
            finish        = (start_count == 16'd0);
        end

        if (finish)
        begin
            moving_next = 1'b0;
            tdiv_next   = 8'd0;
            steps_next  = 16'd0;
            open_next   = dir_next;
            if (by_light_next)
            begin
                cool_next = cfg.cooldown_len;
                ev        = dir_next ? EV_OPENED_LIGHT : EV_CLOSED_LIGHT;
            end
            else
            begin
                ev = dir_next ? EV_OPENED : EV_CLOSED;
            end
        end

        result_next.coil_pattern  = coil_of(phase_next);
        result_next.blind_is_open = open_next;
        result_next.light_mode_on = light_next;
        result_next.motor_busy    = moving_next;
        result_next.event_code    = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 3'd0;
            open_reg      <= 1'b0;
            light_reg     <= 1'b1;
            moving_reg    <= 1'b0;
            dir_reg       <= 1'b0;
            by_light_reg  <= 1'b0;
            steps_reg     <= 16'd0;
            tdiv_reg      <= 8'd0;
            cool_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg    <= phase_next;
                open_reg     <= open_next;
                light_reg    <= light_next;
                moving_reg   <= moving_next;
                dir_reg      <= dir_next;
                by_light_reg <= by_light_next;
                steps_reg    <= steps_next;
                tdiv_reg     <= tdiv_next;
                cool_reg     <= cool_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/core/light_blind_stepper_controller_core.sv
// Top level of the light blind stepper controller: configuration registers,
// front end, operation queue and back end. Depends on lbsc_pkg and all
// lbsc_* modules.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   mode, light_sample, command_byte
// out       output     out_valid/out_stall coil_pattern, blind_is_open,
//                                          light_mode_on, motor_busy, event_code
// apb       input      psel/penable/pready paddr, pwdata, prdata
//
// One result comes out per item, one item per clock when the output is not stalled.
// From input transfer to result, an item passes the queue write and then the
// back-end register. The four-entry queue holds inputs while the output is stalled,
// and in_stall rises only when it is full. Reset is asynchronous and loads the
// register defaults and the idle blind state with light mode on.
module light_blind_stepper_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [9:0]                    light_sample,
    input  logic [7:0]                    command_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    coil_pattern,
    output logic                          blind_is_open,
    output logic                          light_mode_on,
    output logic                          motor_busy,
    output logic [2:0]                    event_code,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lbsc_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       q_push, q_pop, q_empty, q_full;
    item_t      push_item, head_item;
    result_t    result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_thr     <= 10'd520;
            cfg_reg.close_thr    <= 10'd480;
            cfg_reg.open_count   <= 16'd3000;
            cfg_reg.close_count  <= 16'd3000;
            cfg_reg.cooldown_len <= 16'd3000;
            cfg_reg.step_ticks   <= 8'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_OPEN_THR:    cfg_reg.open_thr     <= pwdata[9:0];
                REG_CLOSE_THR:   cfg_reg.close_thr    <= pwdata[9:0];
                REG_OPEN_STEPS:  cfg_reg.open_count   <= pwdata[15:0];
                REG_CLOSE_STEPS: cfg_reg.close_count  <= pwdata[15:0];
                REG_COOLDOWN:    cfg_reg.cooldown_len <= pwdata[15:0];
                REG_STEP_TICKS:  cfg_reg.step_ticks   <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OPEN_THR:    prdata = {22'd0, cfg_reg.open_thr};
            REG_CLOSE_THR:   prdata = {22'd0, cfg_reg.close_thr};
            REG_OPEN_STEPS:  prdata = {16'd0, cfg_reg.open_count};
            REG_CLOSE_STEPS: prdata = {16'd0, cfg_reg.close_count};
            REG_COOLDOWN:    prdata = {16'd0, cfg_reg.cooldown_len};
            REG_STEP_TICKS:  prdata = {24'd0, cfg_reg.step_ticks};
            default:         prdata = 32'd0;
        endcase
    end

    lbsc_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .light_sample (light_sample),
        .command_byte (command_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    lbsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    lbsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign coil_pattern  = result.coil_pattern;
    assign blind_is_open = result.blind_is_open;
    assign light_mode_on = result.light_mode_on;
    assign motor_busy    = result.motor_busy;
    assign event_code    = result.event_code;

    // A finished move never leaves the motor marked busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_OPENED || event_code == EV_CLOSED ||
                      event_code == EV_OPENED_LIGHT || event_code == EV_CLOSED_LIGHT)
        |-> !motor_busy)
        else $error("motor still busy on a finished move");

    // The mode events agree with the reported mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_LIGHT_MODE |-> light_mode_on)
        else $error("light mode event without light mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_MANUAL_MODE |-> !light_mode_on)
        else $error("manual mode event with light mode on");

    // The back end always drains the queue when the output side is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty && !out_stall |-> q_pop)
        else $error("back end idle while work is queued");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for light_blind_stepper_controller_core: directed and random
// ticks and commands, a clocked driver and monitor, and a per-item blind predictor.
// Depends on lbsc_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
    };

    typedef struct {
        logic       is_cmd;
        logic [9:0] sample;
        logic [7:0] cmd;
        logic       hold;
    } blind_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = 1'b0;
    logic [9:0]  light_sample = '0;
    logic [7:0]  command_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  coil_pattern;
    logic        blind_is_open;
    logic        light_mode_on;
    logic        motor_busy;
    logic [2:0]  event_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    light_blind_stepper_controller_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .light_sample  (light_sample),
        .command_byte  (command_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_pattern  (coil_pattern),
        .blind_is_open (blind_is_open),
        .light_mode_on (light_mode_on),
        .motor_busy    (motor_busy),
        .event_code    (event_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cfg_t blind_cfg = '{10'd520, 10'd480, 16'd3000, 16'd3000, 16'd3000, 8'd1};

    logic [2:0]  st_phase = '0;
    logic        st_open = 1'b0;
    logic        st_light = 1'b1;
    logic        st_moving = 1'b0;
    logic        st_dir = 1'b0;
    logic        st_by_light = 1'b0;
    logic [15:0] st_steps = '0;
    logic [7:0]  st_div = '0;
    logic [15:0] st_cool = '0;

    blind_item_t queued_items[$];
    result_t     expected_status[$];
    blind_item_t on_wire;

    int items_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int reg_writes = 0;
    int moves_done = 0;
    int invalid_cmds = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_run = 0;
    int longest_stall = 0;
    int cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 20)
            $display("mismatch at result %0d: %s got %h want %h",
                     results_seen, what, got, want);
    endtask

    function automatic logic [2:0] end_move();
        st_moving = 1'b0;
        st_div = '0;
        st_steps = '0;
        st_open = st_dir;
        moves_done++;
        if (st_by_light)
        begin
            st_cool = blind_cfg.cooldown_len;
            return st_dir ? EV_OPENED_LIGHT : EV_CLOSED_LIGHT;
        end
        return st_dir ? EV_OPENED : EV_CLOSED;
    endfunction

    function automatic logic [2:0] begin_move(input logic dir, input logic by_light);
        st_dir = dir;
        st_by_light = by_light;
        st_steps = dir ? blind_cfg.open_count : blind_cfg.close_count;
        st_div = '0;
        st_moving = 1'b1;
        if (st_steps == 16'd0)
            return end_move();
        return EV_NONE;
    endfunction

    function automatic result_t advance_blind(input blind_item_t it);
        logic [2:0] ev;
        logic [7:0] period;
        result_t    r;
        ev = EV_NONE;
        period = (blind_cfg.step_ticks == 8'd0) ? 8'd1 : blind_cfg.step_ticks;
        if (it.is_cmd)
        begin
            case (it.cmd)
                CHAR_LIGHT:
                begin
                    st_light = 1'b1;
                    ev = EV_LIGHT_MODE;
                end
                CHAR_MANUAL:
                begin
                    st_light = 1'b0;
                    ev = EV_MANUAL_MODE;
                end
                CHAR_OPEN:
                    if (!st_moving && !st_light && !st_open)
                        ev = begin_move(1'b1, 1'b0);
                CHAR_CLOSE:
                    if (!st_moving && !st_light && st_open)
                        ev = begin_move(1'b0, 1'b0);
                default:
                begin
                    ev = EV_INVALID;
                    invalid_cmds++;
                end
            endcase
        end
        else if (st_moving)
        begin
            st_div = st_div + 8'd1;
            if (st_div >= period)
            begin
                st_div = '0;
                st_phase = st_dir ? st_phase + 3'd1 : st_phase - 3'd1;
                st_steps = st_steps - 16'd1;
                if (st_steps == 16'd0)
                    ev = end_move();
            end
        end
        else if (st_cool != 16'd0)
        begin
            st_cool = st_cool - 16'd1;
        end
        else if (st_light)
        begin
            if (!st_open && it.sample > blind_cfg.open_thr)
                ev = begin_move(1'b1, 1'b1);
            else if (st_open && it.sample < blind_cfg.close_thr)
                ev = begin_move(1'b0, 1'b1);
        end
        r.coil_pattern  = HALF_STEP_COILS[st_phase];
        r.blind_is_open = st_open;
        r.light_mode_on = st_light;
        r.motor_busy    = st_moving;
        r.event_code    = ev;
        return r;
    endfunction

    function automatic void push_item(input logic is_cmd, input logic [9:0] sample,
                                      input logic [7:0] cmd, input logic hold);
        blind_item_t it;
        it.is_cmd = is_cmd;
        it.sample = sample;
        it.cmd    = cmd;
        it.hold   = hold;
        queued_items.push_back(it);
    endfunction

    function automatic logic [9:0] pick_sample();
        int v;
        case ($urandom_range(0, 5))
            0:       v = int'(blind_cfg.open_thr) + int'($urandom_range(0, 6)) - 3;
            1:       v = int'(blind_cfg.close_thr) + int'($urandom_range(0, 6)) - 3;
            2:       v = 0;
            3:       v = 1023;
            default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[9:0];
    endfunction

    function automatic logic [7:0] pick_command(input bit no_moves);
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1:    b = CHAR_LIGHT;
            2, 3:    b = CHAR_MANUAL;
            4, 5, 6: b = no_moves ? CHAR_MANUAL : CHAR_OPEN;
            7, 8:    b = no_moves ? CHAR_LIGHT : CHAR_CLOSE;
            default:
            begin
                do
                    b = 8'($urandom);
                while (b == CHAR_LIGHT || b == CHAR_MANUAL || b == CHAR_OPEN
                       || b == CHAR_CLOSE);
            end
        endcase
        return b;
    endfunction

    task automatic reg_set(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] raw;
        logic [31:0] kept;
        case (idx)
            REG_OPEN_THR, REG_CLOSE_THR: mask = 32'h0000_03FF;
            REG_STEP_TICKS:              mask = 32'h0000_00FF;
            default:                     mask = 32'h0000_FFFF;
        endcase
        raw = (value & mask) | ($urandom & ~mask);
        kept = raw & mask;
        case (idx)
            REG_OPEN_THR:    blind_cfg.open_thr = kept[9:0];
            REG_CLOSE_THR:   blind_cfg.close_thr = kept[9:0];
            REG_OPEN_STEPS:  blind_cfg.open_count = kept[15:0];
            REG_CLOSE_STEPS: blind_cfg.close_count = kept[15:0];
            REG_COOLDOWN:    blind_cfg.cooldown_len = kept[15:0];
            default:         blind_cfg.step_ticks = kept[7:0];
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= raw;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== kept)
            report("register readback", prdata, kept);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_config(input int o_thr, input int c_thr, input int o_steps,
                                input int c_steps, input int cool, input int st);
        reg_set(REG_OPEN_THR, o_thr);
        reg_set(REG_CLOSE_THR, c_thr);
        reg_set(REG_OPEN_STEPS, o_steps);
        reg_set(REG_CLOSE_STEPS, c_steps);
        reg_set(REG_COOLDOWN, cool);
        reg_set(REG_STEP_TICKS, st);
    endtask

    task automatic wait_idle();
        while (queued_items.size() != 0 || in_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_status.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_stall)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
            begin
                stall_run = 0;
            end
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(advance_blind(on_wire));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_items.size() > 0
                         && (!queued_items[0].hold || expected_status.size() == 0))
                begin
                    on_wire = queued_items.pop_front();
                    in_valid     <= 1'b1;
                    mode         <= on_wire.is_cmd;
                    light_sample <= on_wire.sample;
                    command_byte <= on_wire.cmd;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                report("result with nothing expected", 32'(event_code), 32'(EV_NONE));
            end
            else
            begin
                want = expected_status.pop_front();
                if (coil_pattern !== want.coil_pattern)
                    report("coil_pattern", 32'(coil_pattern), 32'(want.coil_pattern));
                if (blind_is_open !== want.blind_is_open)
                    report("blind_is_open", 32'(blind_is_open), 32'(want.blind_is_open));
                if (light_mode_on !== want.light_mode_on)
                    report("light_mode_on", 32'(light_mode_on), 32'(want.light_mode_on));
                if (motor_busy !== want.motor_busy)
                    report("motor_busy", 32'(motor_busy), 32'(want.motor_busy));
                if (event_code !== want.event_code)
                    report("event_code", 32'(event_code), 32'(want.event_code));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        int style;
        int style_left;
        int hold_left;
        int next_hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            style = 0;
            style_left = 0;
            hold_left = 0;
            next_hold = 700;
        end
        else
        begin
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(64, 256);
            end
            else
            begin
                style_left--;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (results_seen >= next_hold && queued_items.size() > 20)
            begin
                hold_left = 150 + $urandom_range(0, 100);
                next_hold = next_hold + 800;
                out_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 25);
                    2:       out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        int         mid;
        int         hyst;
        int         o_thr;
        int         c_thr;
        int         st;
        int         o_steps;
        int         c_steps;
        int         cool;
        bit         no_moves;
        logic       hold_it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: a sample equal to the open threshold must not open.
        push_item(1'b0, 10'd520, 8'hFF, 1'b0);
        push_item(1'b1, 10'h3FF, 8'h00, 1'b0);
        push_item(1'b1, 10'h000, 8'hFF, 1'b0);
        wait_idle();

        // Short moves: commands during a move, mode change mid-move, cooldown,
        // open and close that do not apply.
        apply_config(600, 400, 3, 2, 2, 1);
        push_item(1'b0, 10'd1023, 8'($urandom), 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_OPEN, 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_CLOSE, 1'b0);
        push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_MANUAL, 1'b0);
        push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
        push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
        push_item(1'b0, 10'd0, 8'($urandom), 1'b0);
        push_item(1'b0, 10'd0, 8'($urandom), 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_OPEN, 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_CLOSE, 1'b1);
        push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
        push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_CLOSE, 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_LIGHT, 1'b0);
        wait_idle();

        // Extreme thresholds, zero step counts and a zero step period.
        apply_config(0, 1023, 0, 0, 0, 0);
        push_item(1'b0, 10'd0, 8'($urandom), 1'b0);
        push_item(1'b0, 10'd1, 8'($urandom), 1'b0);
        push_item(1'b0, 10'd1023, 8'($urandom), 1'b0);
        push_item(1'b0, 10'd1022, 8'($urandom), 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_MANUAL, 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_OPEN, 1'b0);
        push_item(1'b1, 10'($urandom), CHAR_CLOSE, 1'b0);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            no_moves = (p == 4);
            if (no_moves)
            begin
                apply_config(1023, 0, 65535, 65535, 65535, 255);
            end
            else
            begin
                mid = $urandom_range(100, 900);
                hyst = $urandom_range(0, 60);
                o_thr = mid + hyst;
                c_thr = mid - hyst;
                if ($urandom_range(0, 4) == 0)
                begin
                    o_thr = $urandom_range(0, 1023);
                    c_thr = $urandom_range(0, 1023);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    st = $urandom_range(100, 255);
                    o_steps = $urandom_range(0, 2);
                    c_steps = $urandom_range(0, 2);
                end
                else
                begin
                    st = $urandom_range(0, 3);
                    o_steps = $urandom_range(0, 40);
                    c_steps = $urandom_range(0, 40);
                end
                cool = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                  : $urandom_range(0, 12);
                apply_config(o_thr, c_thr, o_steps, c_steps, cool, st);
            end
            for (int i = 0; i < 190; i++)
            begin
                hold_it = (p == 2 && i == 95);
                if ($urandom_range(0, 99) < 72)
                    push_item(1'b0, pick_sample(), 8'($urandom), hold_it);
                else
                    push_item(1'b1, 10'($urandom), pick_command(no_moves), hold_it);
            end
            wait_idle();
            while (st_moving)
            begin
                push_item(1'b1, 10'($urandom), CHAR_MANUAL, 1'b0);
                repeat (64) push_item(1'b0, 10'($urandom), 8'($urandom), 1'b0);
                wait_idle();
            end
        end

        $display("covered %0d input transfers, %0d results checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("moves finished %0d, invalid commands %0d, longest input stall %0d cycles",
                 moves_done, invalid_cmds, longest_stall);
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
